/* hw/rtl/vibrato_delay_modulator_unit_defines.svh */
// Assertion macros for the vibrato delay modulator unit.
// Relies on the asserting module providing clk and rst_n.
`ifndef VIBRATO_DELAY_MODULATOR_UNIT_DEFINES_SVH
`define VIBRATO_DELAY_MODULATOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define VDM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define VDM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VDM_ASSERT_IMPL(lbl, ante, cons, msg)
`define VDM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* hw/rtl/vdm_pkg.sv */
// Shared types, constants and the quarter-wave sine table for the vibrato unit.
// No dependencies.
`default_nettype none

package vdm_pkg;

    localparam int DELAY_DEPTH     = 64;
    localparam int SINE_TABLE_SIZE = 1024;

    localparam int LINE_AW    = $clog2(DELAY_DEPTH);
    localparam int FILL_W     = LINE_AW + 1;
    localparam int SINE_AW    = $clog2(SINE_TABLE_SIZE);
    localparam int QUARTER    = SINE_TABLE_SIZE / 4;
    localparam int QUARTER_AW = SINE_AW - 2;
    localparam int TAP_W      = 8;

    localparam int SAMPLE_W   = 16;
    localparam int STEP_W     = 32;
    localparam int SWING_W    = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int POS_W      = 22;
    localparam int FRAC_W     = 15;
    localparam int ACC_W      = 34;

    localparam logic [STEP_W-1:0]  PHASE_STEP_RESET = 32'd389566;
    localparam logic [SWING_W-1:0] SWING_RESET      = 5'd22;

    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWING_DEPTH = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POS,
        S_RD1,
        S_RD2,
        S_DONE
    } state_t;

    localparam longint SC1     = 64'sd1686629713;
    localparam longint SC3     = 64'sd693598677;
    localparam longint SC5     = 64'sd85569278;
    localparam longint SC7     = 64'sd5026937;
    localparam longint SC9     = 64'sd172283;
    localparam longint Q30_ONE = 64'sd1073741824;

    typedef logic [14:0] sine_rom_t [QUARTER];

    // Odd polynomial in Q30, rounded to Q15 magnitude
    function automatic logic [14:0] sine_mag(longint t);
        longint t2;
        longint r;
        longint s;
        t2 = (t * t) >>> 30;
        r  = SC9;
        r  = SC7 - ((t2 * r) >>> 30);
        r  = SC5 - ((t2 * r) >>> 30);
        r  = SC3 - ((t2 * r) >>> 30);
        r  = SC1 - ((t2 * r) >>> 30);
        s  = (t * r) >>> 30;
        s  = (s + 64'sd16384) >>> 15;
        if (s > 64'sd32767)
            s = 64'sd32767;
        if (s < 64'sd0)
            s = 64'sd0;
        return s[14:0];
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int j = 0; j < QUARTER; j++)
            rom[j] = sine_mag(longint'(j) <<< (30 - QUARTER_AW));
        return rom;
    endfunction

    localparam sine_rom_t   SINE_ROM  = build_sine_rom();
    localparam logic [14:0] SINE_PEAK = sine_mag(Q30_ONE);

    // Tap beyond the line reads the oldest entry
    function automatic logic [LINE_AW-1:0] tap_index(logic [TAP_W-1:0] k);
        if (k > TAP_W'(DELAY_DEPTH - 1))
            return LINE_AW'(DELAY_DEPTH - 1);
        else
            return k[LINE_AW-1:0];
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/vdm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module vdm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* hw/rtl/vdm_sine.sv */
// Registered sine lookup built from the quarter-wave table with mirroring.
// Depends on vdm_pkg.
`default_nettype none

module vdm_sine (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [vdm_pkg::SINE_AW-1:0]   addr,
    output logic signed [vdm_pkg::SAMPLE_W-1:0] sine
);

    logic [1:0]                       quad;
    logic [vdm_pkg::QUARTER_AW-1:0]   j;
    logic [vdm_pkg::QUARTER_AW-1:0]   mirror;
    logic [14:0]                      mag;
    logic signed [vdm_pkg::SAMPLE_W-1:0] sine_next;

    assign quad   = addr[vdm_pkg::SINE_AW-1 -: 2];
    assign j      = addr[vdm_pkg::QUARTER_AW-1:0];
    assign mirror = vdm_pkg::QUARTER_AW'(0) - j;

    always_comb
    begin
        if (quad[0])
            mag = (j == '0) ? vdm_pkg::SINE_PEAK : vdm_pkg::SINE_ROM[mirror];
        else
            mag = vdm_pkg::SINE_ROM[j];
        sine_next = quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    always_ff @(posedge clk)
    begin
        if (en)
            sine <= sine_next;
    end

endmodule

`default_nettype wire

/* hw/rtl/vibrato_delay_modulator_unit.sv */
// Vibrato delay modulator: circular delay line in RAM, sine-swept tap, linear interpolation.
// Depends on vdm_pkg, vdm_ram, vdm_sine and vibrato_delay_modulator_unit_defines.svh.
//
// Usage:
//   Input channel (in_valid/in_stall, sample_in) takes one signed 16-bit sample a beat.
//   Output channel (out_valid/out_stall, sample_out) returns one result per input beat.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes phase_step
//   (index 0) or swing_depth (index 1, low 5 bits); other indexes are ignored.
//   cfg_ready is always high; write only while no sample is in flight.
// Sequence: after an input beat the FSM steps through S_POS, S_RD1, S_RD2 and S_DONE, and
//   the result is loaded into the output register from S_DONE, then shown on sample_out.
// Pacing: a new sample is taken only once the FSM is back in S_IDLE, set by the two tap reads
//   through the single read port of the delay-line RAM and the interpolation multiplies that follow.
// Reset: phase is zero, registers take their defaults, and a fill count makes every
//   delay entry read as zero until written; no clearing pass.
// Stall: a finished result waits in the output register; a new sample is still taken,
//   and its result holds in the final step until the output register frees.
`default_nettype none

`include "vibrato_delay_modulator_unit_defines.svh"

module vibrato_delay_modulator_unit (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic signed [vdm_pkg::SAMPLE_W-1:0] sample_in,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic signed [vdm_pkg::SAMPLE_W-1:0]     sample_out,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [vdm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [vdm_pkg::CFG_DATA_W-1:0]     cfg_data
);

    vdm_pkg::state_t state_reg, state_next;

    logic [vdm_pkg::STEP_W-1:0]   phase_step_reg;
    logic [vdm_pkg::SWING_W-1:0]  swing_reg;
    logic [vdm_pkg::STEP_W-1:0]   phase_reg;
    logic [vdm_pkg::LINE_AW-1:0]  wp_reg;
    logic [vdm_pkg::LINE_AW-1:0]  base_reg;
    logic [vdm_pkg::FILL_W-1:0]   fill_reg;
    logic                         out_valid_reg;
    logic signed [vdm_pkg::SAMPLE_W-1:0] sample_out_reg;

    logic signed [vdm_pkg::SAMPLE_W-1:0] x_reg;
    logic [vdm_pkg::TAP_W-2:0]           whole_reg, whole_next;
    logic [vdm_pkg::FRAC_W-1:0]          frac_reg, frac_next;
    logic                                v0_reg, v0_next;
    logic                                v1_reg, v1_next;
    logic signed [vdm_pkg::ACC_W-1:0]    acc_reg, acc_next;

    logic accept;
    logic out_take;
    logic out_load;

    logic signed [vdm_pkg::SAMPLE_W-1:0] sn;
    logic [vdm_pkg::LINE_AW-1:0]         raddr;
    logic [vdm_pkg::SAMPLE_W-1:0]        rdata;

    logic signed [vdm_pkg::POS_W-1:0]    pos;
    logic [vdm_pkg::LINE_AW-1:0]         idx0, idx1;
    logic signed [vdm_pkg::SAMPLE_W-1:0] tap0, tap1;
    logic [vdm_pkg::FRAC_W:0]            wt0;
    logic signed [vdm_pkg::ACC_W-2:0]    prod0, prod1;
    logic signed [vdm_pkg::ACC_W-1:0]    acc_adj;
    logic signed [vdm_pkg::ACC_W-17:0]   y;
    logic signed [vdm_pkg::SAMPLE_W-1:0] y_sat;

    assign in_stall   = (state_reg != vdm_pkg::S_IDLE);
    assign accept     = in_valid && !in_stall;
    assign out_take   = out_valid_reg && !out_stall;
    assign out_load   = (state_reg == vdm_pkg::S_DONE) && (!out_valid_reg || !out_stall);
    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign cfg_ready  = 1'b1;

    vdm_sine u_sine (
        .clk  (clk),
        .en   (accept),
        .addr (phase_reg[vdm_pkg::STEP_W-1 -: vdm_pkg::SINE_AW]),
        .sine (sn)
    );

    vdm_ram #(
        .WIDTH (vdm_pkg::SAMPLE_W),
        .DEPTH (vdm_pkg::DELAY_DEPTH)
    ) u_line (
        .clk   (clk),
        .we    (accept),
        .waddr (wp_reg),
        .wdata (sample_in),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Delay position in Q15
    assign pos = $signed(vdm_pkg::POS_W'({6'(swing_reg) + 6'd1, 15'd0}))
               + vdm_pkg::POS_W'($signed({1'b0, swing_reg}) * sn);

    assign idx0 = vdm_pkg::tap_index({2'b0, pos[vdm_pkg::POS_W-2:vdm_pkg::FRAC_W]});
    assign idx1 = vdm_pkg::tap_index({1'b0, whole_reg} + vdm_pkg::TAP_W'(1));

    assign tap0  = v0_reg ? $signed(rdata) : '0;
    assign tap1  = v1_reg ? $signed(rdata) : '0;
    assign wt0   = (vdm_pkg::FRAC_W+1)'(1 << vdm_pkg::FRAC_W) - {1'b0, frac_reg};
    assign prod0 = tap0 * $signed({1'b0, wt0});
    assign prod1 = tap1 * $signed({2'b0, frac_reg});

    // Truncate toward zero, then saturate
    assign acc_adj = acc_reg + (acc_reg[vdm_pkg::ACC_W-1] ? vdm_pkg::ACC_W'(65535)
                                                         : vdm_pkg::ACC_W'(0));
    assign y = acc_adj[vdm_pkg::ACC_W-1:16];

    always_comb
    begin
        if (y > $signed((vdm_pkg::ACC_W-16)'(32767)))
            y_sat = 16'sh7FFF;
        else if (y < -$signed((vdm_pkg::ACC_W-16)'(32768)))
            y_sat = 16'sh8000;
        else
            y_sat = y[vdm_pkg::SAMPLE_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        raddr      = base_reg - idx0;
        whole_next = whole_reg;
        frac_next  = frac_reg;
        v0_next    = v0_reg;
        v1_next    = v1_reg;
        acc_next   = acc_reg;
        case (state_reg)
            vdm_pkg::S_IDLE:
            begin
                if (accept)
                    state_next = vdm_pkg::S_POS;
            end
            vdm_pkg::S_POS:
            begin
                raddr      = base_reg - idx0;
                whole_next = {1'b0, pos[vdm_pkg::POS_W-2:vdm_pkg::FRAC_W]};
                frac_next  = pos[vdm_pkg::FRAC_W-1:0];
                v0_next    = {1'b0, idx0} < fill_reg;
                state_next = vdm_pkg::S_RD1;
            end
            vdm_pkg::S_RD1:
            begin
                raddr      = base_reg - idx1;
                v1_next    = {1'b0, idx1} < fill_reg;
                acc_next   = vdm_pkg::ACC_W'($signed({x_reg, 15'd0}))
                           + vdm_pkg::ACC_W'(prod0);
                state_next = vdm_pkg::S_RD2;
            end
            vdm_pkg::S_RD2:
            begin
                acc_next   = acc_reg + vdm_pkg::ACC_W'(prod1);
                state_next = vdm_pkg::S_DONE;
            end
            vdm_pkg::S_DONE:
            begin
                if (out_load)
                    state_next = vdm_pkg::S_IDLE;
            end
            default:
            begin
                state_next = vdm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= vdm_pkg::S_IDLE;
            phase_step_reg <= vdm_pkg::PHASE_STEP_RESET;
            swing_reg      <= vdm_pkg::SWING_RESET;
            phase_reg      <= '0;
            wp_reg         <= '0;
            base_reg       <= '0;
            fill_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    vdm_pkg::REG_PHASE_STEP:  phase_step_reg <= cfg_data;
                    vdm_pkg::REG_SWING_DEPTH: swing_reg <= cfg_data[vdm_pkg::SWING_W-1:0];
                    default: ;
                endcase
            end
            if (accept)
            begin
                phase_reg <= phase_reg + phase_step_reg;
                base_reg  <= wp_reg;
                wp_reg    <= wp_reg + vdm_pkg::LINE_AW'(1);
                if (fill_reg != vdm_pkg::FILL_W'(vdm_pkg::DELAY_DEPTH))
                    fill_reg <= fill_reg + vdm_pkg::FILL_W'(1);
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_take)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            x_reg <= sample_in;
        if (out_load)
            sample_out_reg <= y_sat;
        whole_reg <= whole_next;
        frac_reg  <= frac_next;
        v0_reg    <= v0_next;
        v1_reg    <= v1_next;
        acc_reg   <= acc_next;
    end

    `VDM_ASSERT_NEXT(a_accept_starts, accept, state_reg == vdm_pkg::S_POS, "accept did not start work")
    `VDM_ASSERT_NEXT(a_done_holds, (state_reg == vdm_pkg::S_DONE) && out_valid_reg && out_stall, state_reg == vdm_pkg::S_DONE, "result dropped while output stalled")
    `VDM_ASSERT_NEXT(a_wp_steady, !accept, $stable(wp_reg) && $stable(fill_reg), "line pointer moved without a beat")
    `VDM_ASSERT_IMPL(a_fill_bound, 1'b1, fill_reg <= vdm_pkg::FILL_W'(vdm_pkg::DELAY_DEPTH), "fill count overran")

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for vibrato_delay_modulator_unit: edge-case and random samples,
// each output beat checked against a behavioural model of the swept, interpolated delay.
// Depends on vdm_pkg and the unit's RTL; reads no files.

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import vdm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 300;
    localparam int PHASES      = 8;
    localparam int CHUNKS      = 5;
    localparam int CHUNK_LEN   = 38;
    localparam int ERROR_CAP   = 100;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam longint COEF_1  = 64'sd1686629713;
    localparam longint COEF_3  = 64'sd693598677;
    localparam longint COEF_5  = 64'sd85569278;
    localparam longint COEF_7  = 64'sd5026937;
    localparam longint COEF_9  = 64'sd172283;
    localparam longint Q30_UNIT = 64'sd1073741824;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [SAMPLE_W-1:0] sample_in = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // model state
    logic signed [SAMPLE_W-1:0] sine_lut [0:SINE_TABLE_SIZE-1];
    logic signed [SAMPLE_W-1:0] line_hist [0:DELAY_DEPTH-1];
    logic [STEP_W-1:0] sweep_phase;
    logic [STEP_W-1:0] sweep_step;
    logic [SWING_W-1:0] swing;

    logic [SAMPLE_W-1:0] dry_pending [$];
    logic signed [SAMPLE_W-1:0] mix_due [$];

    int send_gap_max = 10;
    int recv_gap_max = 10;
    int send_wait = 0;
    int recv_wait = 0;
    int fail_count = 0;
    int cycle_count = 0;
    int hold_cycles = 0;
    logic long_hold_req = 1'b0;
    logic receiver_frozen;

    vibrato_delay_modulator_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic signed [SAMPLE_W-1:0] sine_value(int k);
        logic [63:0] turn;
        logic [31:0] p;
        longint t;
        longint t2;
        longint r;
        longint s;
        turn = (64'(k) << 32) / 64'(SINE_TABLE_SIZE);
        p = turn[31:0];
        t = longint'(p[29:0]);
        if (p[30])
            t = Q30_UNIT - t;
        t2 = (t * t) >>> 30;
        r = COEF_9;
        r = COEF_7 - ((t2 * r) >>> 30);
        r = COEF_5 - ((t2 * r) >>> 30);
        r = COEF_3 - ((t2 * r) >>> 30);
        r = COEF_1 - ((t2 * r) >>> 30);
        s = (t * r) >>> 30;
        s = (s + 64'sd16384) >>> 15;
        if (s > 64'sd32767)
            s = 64'sd32767;
        if (s < 64'sd0)
            s = 64'sd0;
        if (p[31])
            s = -s;
        return SAMPLE_W'(s);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] tap_at(int unsigned k);
        if (k > DELAY_DEPTH - 1)
            k = DELAY_DEPTH - 1;
        return line_hist[k];
    endfunction

    task automatic vibrato_mix(input logic signed [SAMPLE_W-1:0] x,
                               output logic signed [SAMPLE_W-1:0] y);
        logic [63:0] scaled;
        int unsigned addr;
        int unsigned whole;
        int unsigned frac;
        int pos;
        longint acc;
        longint q;
        for (int k = DELAY_DEPTH - 1; k > 0; k--)
            line_hist[k] = line_hist[k-1];
        line_hist[0] = x;
        scaled = 64'(sweep_phase) * 64'(SINE_TABLE_SIZE);
        addr = scaled[63:32];
        if (addr > SINE_TABLE_SIZE - 1)
            addr = SINE_TABLE_SIZE - 1;
        pos = ((1 + int'(swing)) << 15) + int'(swing) * int'(sine_lut[addr]);
        whole = pos >> 15;
        frac = pos & 32'h7FFF;
        acc = longint'(x) * 32768
            + longint'(tap_at(whole + 1)) * longint'(frac)
            + longint'(tap_at(whole)) * (64'sd32768 - longint'(frac));
        q = acc / 65536;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        y = SAMPLE_W'(q);
        sweep_phase = sweep_phase + sweep_step;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_PHASE_STEP:  sweep_step = data[STEP_W-1:0];
            REG_SWING_DEPTH: swing = data[SWING_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (dry_pending.size() != 0 || in_valid || mix_due.size() != 0)
            @(negedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] draw_sample();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($urandom_range(0, 64) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    // input side: one beat per pending sample, random gap after each
    always @(posedge clk) begin : drive_beats
        logic signed [SAMPLE_W-1:0] y;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                vibrato_mix(sample_in, y);
                mix_due.push_back(y);
            end
            if (!in_valid || !in_stall) begin
                if (send_wait > 0) begin
                    send_wait--;
                    in_valid <= 1'b0;
                end
                else if (dry_pending.size() != 0) begin
                    in_valid  <= 1'b1;
                    sample_in <= dry_pending.pop_front();
                    send_wait = $urandom_range(0, send_gap_max);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
        if (long_hold_req && hold_cycles < LONG_HOLD)
            hold_cycles <= hold_cycles + 1;

    assign receiver_frozen = long_hold_req && hold_cycles < LONG_HOLD;

    // output side: check each beat, then stall for a random spell
    always @(posedge clk) begin : watch_beats
        logic signed [SAMPLE_W-1:0] want;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (mix_due.size() == 0) begin
                    fail_count++;
                    if (fail_count <= ERROR_CAP)
                        $error("sample_out: expected nothing, got %0d", sample_out);
                end
                else begin
                    want = mix_due.pop_front();
                    if (sample_out !== want) begin
                        fail_count++;
                        if (fail_count <= ERROR_CAP)
                            $error("sample_out: expected %0d, got %0d", want, sample_out);
                    end
                end
                recv_wait = $urandom_range(0, recv_gap_max);
            end
            if (receiver_frozen)
                out_stall <= 1'b1;
            else if (recv_wait > 0) begin
                recv_wait--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        logic [SAMPLE_W-1:0] directed [24];
        logic [STEP_W-1:0] step_set [PHASES];
        logic [SWING_W-1:0] swing_set [PHASES];

        for (int k = 0; k < SINE_TABLE_SIZE; k++)
            sine_lut[k] = sine_value(k);
        for (int k = 0; k < DELAY_DEPTH; k++)
            line_hist[k] = '0;
        sweep_phase = '0;
        sweep_step  = PHASE_STEP_RESET;
        swing       = SWING_RESET;

        directed = '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h0000, 16'h0001,
                     16'hFFFF, 16'h5555, 16'hAAAA, 16'h7FFF, 16'h8000, 16'h0000,
                     16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF,
                     16'h7FFF, 16'h8000, 16'h1234, 16'hEDCC, 16'h7FFF, 16'h8000};
        step_set  = '{32'd0, 32'hFFFF_FFFF, 32'h8000_0000, PHASE_STEP_RESET,
                      32'h0100_0000, 32'($urandom), 32'($urandom_range(0, 2000000)),
                      32'($urandom)};
        swing_set = '{5'd31, 5'd0, 5'd1, SWING_RESET, 5'($urandom_range(0, 31)), 5'd30,
                      5'($urandom), 5'd15};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset defaults, empty line
        @(negedge clk);
        for (int i = 0; i < 12; i++)
            dry_pending.push_back(directed[i]);
        wait_drained();

        // widest swing with phase wrapping every beat; upper data bits must be dropped
        write_reg(REG_PHASE_STEP, 32'hFFFF_FFFF);
        write_reg(REG_SWING_DEPTH, 32'hFFFF_FFFF);
        @(negedge clk);
        for (int i = 12; i < 18; i++)
            dry_pending.push_back(directed[i]);
        wait_drained();

        // writes to unused indexes change nothing; then phase step and swing depth go to zero
        write_reg(REG_SPARE_A, 32'($urandom));
        write_reg(REG_SPARE_B, 32'($urandom));
        write_reg(REG_PHASE_STEP, 32'd0);
        write_reg(REG_SWING_DEPTH, 32'd0);
        @(negedge clk);
        for (int i = 18; i < 24; i++)
            dry_pending.push_back(directed[i]);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            if ($urandom_range(0, 1)) begin
                write_reg(REG_PHASE_STEP, step_set[ph]);
                write_reg(REG_SWING_DEPTH, {27'($urandom), swing_set[ph]});
            end
            else begin
                write_reg(REG_SWING_DEPTH, {27'($urandom), swing_set[ph]});
                write_reg(REG_PHASE_STEP, step_set[ph]);
            end
            if (ph == 2) begin
                write_reg(REG_SPARE_B, 32'($urandom));
                write_reg(REG_SPARE_A, 32'($urandom));
            end
            for (int c = 0; c < CHUNKS; c++) begin
                @(negedge clk);
                send_gap_max = $urandom_range(0, 1) ? 10 : 0;
                recv_gap_max = $urandom_range(0, 1) ? 10 : 0;
                // receiver holds off while the sender keeps offering beats
                if (ph == 3 && c == 1) begin
                    send_gap_max = 0;
                    long_hold_req = 1'b1;
                end
                repeat (CHUNK_LEN)
                    dry_pending.push_back(draw_sample());
                if (c == 2)
                    wait_drained();
                else begin
                    while (dry_pending.size() >= 8)
                        @(negedge clk);
                end
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/vdm_pkg.sv
hw/rtl/vdm_ram.sv
hw/rtl/vdm_sine.sv
hw/rtl/vibrato_delay_modulator_unit.sv
bench/testbench.sv
